### hw/rtl/aliquot_sum_amicable_test_assert.svh
// Assertion macros for the aliquot-sum amicable test block
`ifndef ALIQUOT_SUM_AMICABLE_TEST_ASSERT_SVH
`define ALIQUOT_SUM_AMICABLE_TEST_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during rst
`define ASA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst
`define ASA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/aliq_pkg.sv
// Shared constants and state types for the aliquot-sum amicable test block
`default_nettype none

package aliq_pkg;

  localparam int NUM_W          = 20;  // width of the number port
  localparam int SUM_W          = 23;  // width of the reported sums
  localparam int INPUT_BITS_DEF = 20;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_DIV,
    S_ADDQ
  } sum_state_t;

  typedef enum logic [2:0] {
    T_IDLE,
    T_FIRST,
    T_START2,
    T_SECOND,
    T_DELIVER
  } top_state_t;

endpackage

`default_nettype wire

### hw/rtl/aliq_div.sv
// Restoring radix-2 divider, one quotient bit per cycle
`default_nettype none

module aliq_div #(
  parameter int W = 23
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  input  wire logic [W-1:0] dividend,
  input  wire logic [W-1:0] divisor,
  output logic              done,
  output logic [W-1:0]      quotient,
  output logic [W-1:0]      remainder
);

  localparam int CNT_W = $clog2(W);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [W-1:0]     rem;
  logic [W-1:0]     quo;
  logic [W-1:0]     dvs;

  logic [W:0]       shifted;
  logic [W:0]       diff;
  logic             fits;

  assign shifted = {rem, quo[W-1]};
  assign diff    = shifted - {1'b0, dvs};
  assign fits    = ~diff[W];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      rem <= fits ? diff[W-1:0] : shifted[W-1:0];
      quo <= {quo[W-2:0], fits};
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

`default_nettype wire

### hw/rtl/aliq_sum.sv
// Trial-division sequencer: forms 1 + sum of divisor pairs of one operand
`default_nettype none

module aliq_sum #(
  parameter int W  = 23,
  parameter int AW = 26
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  input  wire logic [W-1:0] operand,
  output logic              done,
  output logic [AW-1:0]     sum
);

  aliq_pkg::sum_state_t state, state_next;

  logic [W-1:0]  m_r;
  logic [W-1:0]  d;
  logic [W:0]    sq;     // d*d, kept by running increments
  logic [AW-1:0] acc;

  logic          in_range;
  logic          div_start;
  logic          div_done;
  logic [W-1:0]  quo;
  logic [W-1:0]  rem;
  logic          hit;
  logic          pair;

  assign in_range = (sq <= (W+1)'(m_r));
  assign hit      = (rem == '0);
  assign pair     = hit && (quo != d);

  aliq_div #(.W(W)) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (m_r),
    .divisor   (d),
    .done      (div_done),
    .quotient  (quo),
    .remainder (rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= aliq_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      aliq_pkg::S_IDLE:  if (start) state_next = aliq_pkg::S_CHECK;
      aliq_pkg::S_CHECK: state_next = in_range ? aliq_pkg::S_DIV : aliq_pkg::S_IDLE;
      aliq_pkg::S_DIV: begin
        if (div_done) state_next = pair ? aliq_pkg::S_ADDQ : aliq_pkg::S_CHECK;
      end
      aliq_pkg::S_ADDQ:  state_next = aliq_pkg::S_CHECK;
      default:           state_next = aliq_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    div_start = 1'b0;
    done      = 1'b0;
    unique case (state)
      aliq_pkg::S_CHECK: begin
        div_start = in_range;
        done      = ~in_range;
      end
      default: begin
        div_start = 1'b0;
        done      = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == aliq_pkg::S_IDLE && start) begin
      m_r <= operand;
      d   <= W'(2);
      sq  <= (W+1)'(4);
      acc <= AW'(1);
    end else if (state == aliq_pkg::S_DIV && div_done) begin
      if (hit) begin
        acc <= acc + AW'(d);
      end
      if (!pair) begin
        d  <= d + W'(1);
        sq <= sq + {d, 1'b1};
      end
    end else if (state == aliq_pkg::S_ADDQ) begin
      acc <= acc + AW'(quo);
      d   <= d + W'(1);
      sq  <= sq + {d, 1'b1};
    end
  end

  assign sum = acc;

endmodule

`default_nettype wire

### hw/rtl/aliquot_sum_amicable_test.sv
// Work per item: one trial division per divisor over d = 2..isqrt(n)
//   and d = 2..isqrt(s), plus an S_ADDQ step per divisor pair (d != m/d); W = min(INPUT_BITS,20)+3.
// Throughput: one item at a time; in_ready is high only while no item is in work.
//   A finished result sits in the output register while the next item is taken.
// Reset: synchronous active-high rst returns to idle and clears out_valid.
// Aliquot-sum amicable test: top level
`default_nettype none

module aliquot_sum_amicable_test #(
  parameter int INPUT_BITS = aliq_pkg::INPUT_BITS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [aliq_pkg::NUM_W-1:0] number,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [aliq_pkg::SUM_W-1:0]      divisor_sum,
  output logic [aliq_pkg::SUM_W-1:0]      partner_sum,
  output logic                            amicable
);

  // bits of number that count; only those below INPUT_BITS are used
  localparam int EFF_BITS = (INPUT_BITS < aliq_pkg::NUM_W) ? INPUT_BITS : aliq_pkg::NUM_W;
  localparam int OP_W     = EFF_BITS + 3;  // holds n and s
  localparam int ACC_W    = EFF_BITS + 6;  // holds t at full precision

  aliq_pkg::top_state_t state, state_next;

  logic [OP_W-1:0]  n_reg;
  logic [ACC_W-1:0] s_reg;
  logic [ACC_W-1:0] t_reg;
  logic             flag_reg;

  logic             accept;
  logic             sum_start;
  logic             sum_done;
  logic [OP_W-1:0]  sum_operand;
  logic [ACC_W-1:0] sum_result;
  logic [OP_W-1:0]  n_in;
  logic             load_out;
  logic             in_pass;

  assign n_in   = OP_W'(number[EFF_BITS-1:0]);
  assign accept = in_valid && in_ready;

  assign sum_operand = (state == aliq_pkg::T_IDLE) ? n_in : s_reg[OP_W-1:0];

  assign in_pass = (state == aliq_pkg::T_FIRST) || (state == aliq_pkg::T_SECOND);

  aliq_sum #(.W(OP_W), .AW(ACC_W)) u_sum (
    .clk     (clk),
    .rst     (rst),
    .start   (sum_start),
    .operand (sum_operand),
    .done    (sum_done),
    .sum     (sum_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= aliq_pkg::T_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      aliq_pkg::T_IDLE:    if (in_valid) state_next = aliq_pkg::T_FIRST;
      aliq_pkg::T_FIRST:   if (sum_done) state_next = aliq_pkg::T_START2;
      aliq_pkg::T_START2:  state_next = aliq_pkg::T_SECOND;
      aliq_pkg::T_SECOND:  if (sum_done) state_next = aliq_pkg::T_DELIVER;
      aliq_pkg::T_DELIVER: if (!out_valid || out_ready) state_next = aliq_pkg::T_IDLE;
      default:             state_next = aliq_pkg::T_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    sum_start = 1'b0;
    load_out  = 1'b0;
    unique case (state)
      aliq_pkg::T_IDLE: begin
        in_ready  = 1'b1;
        sum_start = in_valid;
      end
      aliq_pkg::T_START2:  sum_start = 1'b1;
      aliq_pkg::T_DELIVER: load_out  = ~out_valid | out_ready;
      default: begin
        in_ready  = 1'b0;
        sum_start = 1'b0;
        load_out  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      n_reg <= n_in;
    end
    if (state == aliq_pkg::T_FIRST && sum_done) begin
      s_reg <= sum_result;
    end
    if (state == aliq_pkg::T_SECOND && sum_done) begin
      t_reg    <= sum_result;
      flag_reg <= (sum_result == ACC_W'(n_reg)) && (ACC_W'(n_reg) != s_reg);
    end
    if (load_out) begin
      divisor_sum <= aliq_pkg::SUM_W'(s_reg);
      partner_sum <= aliq_pkg::SUM_W'(t_reg);
      amicable    <= flag_reg;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  `include "aliquot_sum_amicable_test_assert.svh"

  `ASA_ASSERT_NOW(a_done_in_pass, sum_done, in_pass, "divisor-sum unit finished outside a pass")
  `ASA_ASSERT_NEXT(a_busy_after_accept, accept, !in_ready, "item accepted while busy")
  `ASA_ASSERT_NEXT(a_result_loaded, load_out, out_valid, "result load did not raise out_valid")

endmodule

`default_nettype wire
